### design/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PCT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PCT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/pct_pkg.sv
package pct_pkg;

   localparam int CW = 32;
   localparam int TW = 48;
   localparam int DIM_DEFAULT = 3;
   localparam int FRAC_DEFAULT = 24;
   localparam logic [CW-1:0] CD_RESET = 32'd335544;

endpackage

### design/pct_if.sv
interface pct_req_if;
   logic valid;
   logic ready;
   logic signed [pct_pkg::CW-1:0] pos_a_x;
   logic signed [pct_pkg::CW-1:0] pos_a_y;
   logic signed [pct_pkg::CW-1:0] pos_a_z;
   logic signed [pct_pkg::CW-1:0] pos_b_x;
   logic signed [pct_pkg::CW-1:0] pos_b_y;
   logic signed [pct_pkg::CW-1:0] pos_b_z;
   logic signed [pct_pkg::CW-1:0] vel_a_x;
   logic signed [pct_pkg::CW-1:0] vel_a_y;
   logic signed [pct_pkg::CW-1:0] vel_a_z;
   logic signed [pct_pkg::CW-1:0] vel_b_x;
   logic signed [pct_pkg::CW-1:0] vel_b_y;
   logic signed [pct_pkg::CW-1:0] vel_b_z;

   modport source (
      output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
             vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
      input  ready
   );
   modport sink (
      input  valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
             vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
      output ready
   );
endinterface

interface pct_rsp_if;
   logic valid;
   logic ready;
   logic no_hit;
   logic signed [pct_pkg::TW-1:0] hit_time;

   modport source (output valid, no_hit, hit_time, input ready);
   modport sink (input valid, no_hit, hit_time, output ready);
endinterface

interface pct_csr_if;
   logic valid;
   logic ready;
   logic [pct_pkg::CW-1:0] contact_distance;

   modport source (output valid, contact_distance, input ready);
   modport sink (input valid, contact_distance, output ready);
endinterface

### design/pair_collision_time.sv
// channel   dir   fields
// req_ch    in    pos_a_x..z, pos_b_x..z, vel_a_x..z, vel_b_x..z
// rsp_ch    out   no_hit, hit_time
// csr_ch    in    contact_distance
//
// one item enters per cycle while the output is not stalled; the pipeline holds
// the bit-per-stage square root (67 stages) and the bit-per-stage divider
// (48 stages)
// synchronous reset clears all valid bits and loads contact_distance
// a stalled output holds the whole pipeline; bubbles travel with the items
module pair_collision_time #(
   parameter int DIMENSIONS    = pct_pkg::DIM_DEFAULT,
   parameter int FRACTION_BITS = pct_pkg::FRAC_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   pct_req_if.sink    req_ch,
   pct_rsp_if.source  rsp_ch,
   pct_csr_if.sink    csr_ch
);

   localparam int CW  = pct_pkg::CW;
   localparam int TW  = pct_pkg::TW;
   localparam int DW  = CW + 1;
   localparam int PW  = 2 * DW;
   localparam int HW  = DW;
   localparam int SW  = PW + 2;
   localparam int VW  = PW;
   localparam int MW  = PW + 1;
   localparam int XW  = 2 * PW;
   localparam int RW  = XW + 2;
   localparam int RTW = RW / 2;
   localparam int RMW = RTW + 3;
   localparam int NMW = RTW;
   localparam int DRW = VW + 1;
   localparam int SHR = TW - FRACTION_BITS;
   localparam int LW  = NMW + FRACTION_BITS;
   localparam int NST = 8 + RTW + 2 + TW + 1;
   localparam logic [TW-1:0] MAXP = {1'b0, {(TW-1){1'b1}}};
   localparam logic [TW-1:0] MINM = {1'b1, {(TW-1){1'b0}}};

   logic en;
   logic [NST-1:0] vld_ff;

   // contact distance and its square
   logic [CW-1:0]   cd_ff;
   logic [2*CW-1:0] sb_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_ff <= pct_pkg::CD_RESET;
      end else if (csr_ch.valid) begin
         cd_ff <= csr_ch.contact_distance;
      end
      sb_ff <= (2*CW)'(cd_ff) * (2*CW)'(cd_ff);
   end

   assign en = !vld_ff[NST-1] || rsp_ch.ready;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_ch.valid};
      end
   end

   // stage 0: differences
   logic signed [CW-1:0] pa [3];
   logic signed [CW-1:0] pb [3];
   logic signed [CW-1:0] va [3];
   logic signed [CW-1:0] vb [3];
   assign pa[0] = req_ch.pos_a_x;
   assign pa[1] = req_ch.pos_a_y;
   assign pa[2] = req_ch.pos_a_z;
   assign pb[0] = req_ch.pos_b_x;
   assign pb[1] = req_ch.pos_b_y;
   assign pb[2] = req_ch.pos_b_z;
   assign va[0] = req_ch.vel_a_x;
   assign va[1] = req_ch.vel_a_y;
   assign va[2] = req_ch.vel_a_z;
   assign vb[0] = req_ch.vel_b_x;
   assign vb[1] = req_ch.vel_b_y;
   assign vb[2] = req_ch.vel_b_z;

   logic signed [DW-1:0] dx_in [DIMENSIONS];
   logic signed [DW-1:0] dv_in [DIMENSIONS];
   logic signed [DW-1:0] dx_ff [DIMENSIONS];
   logic signed [DW-1:0] dv_ff [DIMENSIONS];

   always_comb begin
      for (int i = 0; i < DIMENSIONS; i++) begin
         dx_in[i] = DW'(pb[i]) - DW'(pa[i]);
         dv_in[i] = DW'(vb[i]) - DW'(va[i]);
      end
   end

   // stage 1: products
   logic signed [PW-1:0] pxv_ff [DIMENSIONS];
   logic signed [PW-1:0] pvv_ff [DIMENSIONS];
   logic signed [PW-1:0] pxx_ff [DIMENSIONS];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < DIMENSIONS; i++) begin
            dx_ff[i]  <= dx_in[i];
            dv_ff[i]  <= dv_in[i];
            pxv_ff[i] <= PW'(dx_ff[i]) * PW'(dv_ff[i]);
            pvv_ff[i] <= PW'(dv_ff[i]) * PW'(dv_ff[i]);
            pxx_ff[i] <= PW'(dx_ff[i]) * PW'(dx_ff[i]);
         end
      end
   end

   // stage 2: dot products
   logic signed [SW-1:0] dvdx_in, vvs_in, xxs_in;
   logic signed [SW-1:0] dvdx_ff;
   logic [VW-1:0] vv2_ff, xx2_ff;

   always_comb begin
      dvdx_in = '0;
      vvs_in  = '0;
      xxs_in  = '0;
      for (int i = 0; i < DIMENSIONS; i++) begin
         dvdx_in = dvdx_in + SW'(pxv_ff[i]);
         vvs_in  = vvs_in + SW'(pvv_ff[i]);
         xxs_in  = xxs_in + SW'(pxx_ff[i]);
      end
   end

   // stage 3: approach test, -dv.dx, |dx.dx - sigma^2|
   logic app3_ff, ege3_ff;
   logic [VW-1:0] d1_3_ff, vv3_ff, e3_ff;
   logic [VW-1:0] sbw;
   logic ege_in;

   assign sbw = VW'(sb_ff);
   assign ege_in = xx2_ff >= sbw;

   always_ff @(posedge clock) begin
      if (en) begin
         dvdx_ff <= dvdx_in;
         vv2_ff  <= VW'(vvs_in);
         xx2_ff  <= VW'(xxs_in);
         app3_ff <= dvdx_ff[SW-1];
         ege3_ff <= ege_in;
         d1_3_ff <= VW'(-dvdx_ff);
         vv3_ff  <= vv2_ff;
         e3_ff   <= ege_in ? (xx2_ff - sbw) : (sbw - xx2_ff);
      end
   end

   // stages 4-6: wide square of -dv.dx and product vv*e through half-width partial products
   logic app4_ff, ege4_ff, app5_ff, ege5_ff, app6_ff, ege6_ff;
   logic [VW-1:0] d1_4_ff, vv4_ff, d1_5_ff, vv5_ff, d1_6_ff, vv6_ff;
   logic [PW-1:0] dll_ff, dlh_ff, dhh_ff, vll_ff, vlh_ff, vhl_ff, vhh_ff;
   logic [MW-1:0] dm_ff, vm_ff;
   logic [PW-1:0] dll5_ff, dhh5_ff, vll5_ff, vhh5_ff;
   logic [XW-1:0] d1sq_ff, ve_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         app4_ff <= app3_ff;
         ege4_ff <= ege3_ff;
         d1_4_ff <= d1_3_ff;
         vv4_ff  <= vv3_ff;
         dll_ff  <= PW'(d1_3_ff[HW-1:0]) * PW'(d1_3_ff[HW-1:0]);
         dlh_ff  <= PW'(d1_3_ff[HW-1:0]) * PW'(d1_3_ff[VW-1:HW]);
         dhh_ff  <= PW'(d1_3_ff[VW-1:HW]) * PW'(d1_3_ff[VW-1:HW]);
         vll_ff  <= PW'(vv3_ff[HW-1:0]) * PW'(e3_ff[HW-1:0]);
         vlh_ff  <= PW'(vv3_ff[HW-1:0]) * PW'(e3_ff[VW-1:HW]);
         vhl_ff  <= PW'(vv3_ff[VW-1:HW]) * PW'(e3_ff[HW-1:0]);
         vhh_ff  <= PW'(vv3_ff[VW-1:HW]) * PW'(e3_ff[VW-1:HW]);

         app5_ff <= app4_ff;
         ege5_ff <= ege4_ff;
         d1_5_ff <= d1_4_ff;
         vv5_ff  <= vv4_ff;
         dm_ff   <= MW'(dlh_ff) << 1;
         vm_ff   <= MW'(vlh_ff) + MW'(vhl_ff);
         dll5_ff <= dll_ff;
         dhh5_ff <= dhh_ff;
         vll5_ff <= vll_ff;
         vhh5_ff <= vhh_ff;

         app6_ff <= app5_ff;
         ege6_ff <= ege5_ff;
         d1_6_ff <= d1_5_ff;
         vv6_ff  <= vv5_ff;
         d1sq_ff <= {dhh5_ff, dll5_ff} + (XW'(dm_ff) << HW);
         ve_ff   <= {vhh5_ff, vll5_ff} + (XW'(vm_ff) << HW);
      end
   end

   // stage 7: discriminant
   logic nh7_ff;
   logic [RW-1:0] disc7_ff;
   logic [VW-1:0] d1_7_ff, vv7_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         nh7_ff   <= !app6_ff || (ege6_ff && (d1sq_ff < ve_ff));
         disc7_ff <= ege6_ff ? (RW'(d1sq_ff) - RW'(ve_ff)) : (RW'(d1sq_ff) + RW'(ve_ff));
         d1_7_ff  <= d1_6_ff;
         vv7_ff   <= vv6_ff;
      end
   end

   // square root, one root bit per stage
   logic [RW-1:0]  sq_rad_ff  [RTW];
   logic [RMW-1:0] sq_rem_ff  [RTW];
   logic [RTW-1:0] sq_root_ff [RTW];
   logic [VW-1:0]  sq_d1_ff   [RTW];
   logic [VW-1:0]  sq_vv_ff   [RTW];
   logic           sq_nh_ff   [RTW];

   for (genvar j = 0; j < RTW; j++) begin : g_sqrt
      logic [RW-1:0]  rad_src;
      logic [RMW-1:0] rem_src, rem2_in, trial_in;
      logic [RTW-1:0] root_src;
      logic [VW-1:0]  d1_src, vv_src;
      logic           nh_src;

      if (j == 0) begin : g_first
         assign rad_src  = disc7_ff;
         assign rem_src  = '0;
         assign root_src = '0;
         assign d1_src   = d1_7_ff;
         assign vv_src   = vv7_ff;
         assign nh_src   = nh7_ff;
      end else begin : g_next
         assign rad_src  = sq_rad_ff[j-1];
         assign rem_src  = sq_rem_ff[j-1];
         assign root_src = sq_root_ff[j-1];
         assign d1_src   = sq_d1_ff[j-1];
         assign vv_src   = sq_vv_ff[j-1];
         assign nh_src   = sq_nh_ff[j-1];
      end

      assign rem2_in  = {rem_src[RMW-3:0], rad_src[RW-1:RW-2]};
      assign trial_in = (RMW'(root_src) << 2) | RMW'(1);

      always_ff @(posedge clock) begin
         if (en) begin
            sq_rad_ff[j] <= rad_src << 2;
            if (rem2_in >= trial_in) begin
               sq_rem_ff[j]  <= rem2_in - trial_in;
               sq_root_ff[j] <= {root_src[RTW-2:0], 1'b1};
            end else begin
               sq_rem_ff[j]  <= rem2_in;
               sq_root_ff[j] <= {root_src[RTW-2:0], 1'b0};
            end
            sq_d1_ff[j] <= d1_src;
            sq_vv_ff[j] <= vv_src;
            sq_nh_ff[j] <= nh_src;
         end
      end
   end

   // numerator and saturation test
   logic [NMW-1:0] root_w, d1_w, num_ff;
   logic [VW-1:0]  vvn_ff, vvs_ff;
   logic           nhn_ff, negn_ff, nhs_ff, negs_ff, sat_ff;
   logic [DRW-1:0] rems_ff;
   logic [TW-1:0]  los_ff;
   logic [LW-1:0]  nshift;

   assign root_w = sq_root_ff[RTW-1];
   assign d1_w   = NMW'(sq_d1_ff[RTW-1]);
   assign nshift = LW'(num_ff) << FRACTION_BITS;

   always_ff @(posedge clock) begin
      if (en) begin
         negn_ff <= root_w > d1_w;
         num_ff  <= (root_w > d1_w) ? (root_w - d1_w) : (d1_w - root_w);
         vvn_ff  <= sq_vv_ff[RTW-1];
         nhn_ff  <= sq_nh_ff[RTW-1];

         sat_ff  <= (num_ff >> SHR) >= NMW'(vvn_ff);
         rems_ff <= DRW'(num_ff >> SHR);
         los_ff  <= nshift[TW-1:0];
         vvs_ff  <= vvn_ff;
         nhs_ff  <= nhn_ff;
         negs_ff <= negn_ff;
      end
   end

   // restoring divider, one quotient bit per stage
   logic [DRW-1:0] dv_rem_ff [TW];
   logic [TW-1:0]  dv_lo_ff  [TW];
   logic [TW-1:0]  dv_q_ff   [TW];
   logic [VW-1:0]  dv_vv_ff  [TW];
   logic           dv_nh_ff  [TW];
   logic           dv_neg_ff [TW];
   logic           dv_sat_ff [TW];

   for (genvar k = 0; k < TW; k++) begin : g_div
      logic [DRW-1:0] rem_src, rem2_in, vvx;
      logic [TW-1:0]  lo_src, q_src;
      logic [VW-1:0]  vv_src;
      logic           nh_src, neg_src, sat_src;

      if (k == 0) begin : g_first
         assign rem_src = rems_ff;
         assign lo_src  = los_ff;
         assign q_src   = '0;
         assign vv_src  = vvs_ff;
         assign nh_src  = nhs_ff;
         assign neg_src = negs_ff;
         assign sat_src = sat_ff;
      end else begin : g_next
         assign rem_src = dv_rem_ff[k-1];
         assign lo_src  = dv_lo_ff[k-1];
         assign q_src   = dv_q_ff[k-1];
         assign vv_src  = dv_vv_ff[k-1];
         assign nh_src  = dv_nh_ff[k-1];
         assign neg_src = dv_neg_ff[k-1];
         assign sat_src = dv_sat_ff[k-1];
      end

      assign rem2_in = {rem_src[DRW-2:0], lo_src[TW-1]};
      assign vvx     = DRW'(vv_src);

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem2_in >= vvx) begin
               dv_rem_ff[k] <= rem2_in - vvx;
               dv_q_ff[k]   <= {q_src[TW-2:0], 1'b1};
            end else begin
               dv_rem_ff[k] <= rem2_in;
               dv_q_ff[k]   <= {q_src[TW-2:0], 1'b0};
            end
            dv_lo_ff[k]  <= lo_src << 1;
            dv_vv_ff[k]  <= vv_src;
            dv_nh_ff[k]  <= nh_src;
            dv_neg_ff[k] <= neg_src;
            dv_sat_ff[k] <= sat_src;
         end
      end
   end

   // output stage: sign and clamp
   logic [TW-1:0] q_w, time_in, out_t_ff;
   logic          out_nh_ff;

   assign q_w = dv_q_ff[TW-1];

   always_comb begin
      if (dv_nh_ff[TW-1]) begin
         time_in = '0;
      end else if (dv_neg_ff[TW-1]) begin
         time_in = (dv_sat_ff[TW-1] || q_w > MINM) ? MINM : (~q_w + TW'(1));
      end else begin
         time_in = (dv_sat_ff[TW-1] || q_w > MAXP) ? MAXP : q_w;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_nh_ff <= dv_nh_ff[TW-1];
         out_t_ff  <= time_in;
      end
   end

   assign rsp_ch.valid    = vld_ff[NST-1];
   assign rsp_ch.no_hit   = out_nh_ff;
   assign rsp_ch.hit_time = out_t_ff;

endmodule

### design/pct_checker.sv
`include "assert_macros.svh"

module pct_props (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_no_hit,
   input logic [pct_pkg::TW-1:0]      rsp_hit_time
);

   `PCT_ASSERT_IMP(a_nohit_zero, clock, reset, rsp_valid && rsp_no_hit,
      rsp_hit_time == '0, "no_hit item carries a time")
   `PCT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_hit_time) && $stable(rsp_no_hit), "stalled item changed")
   `PCT_ASSERT_IMP(a_req_flow, clock, reset, req_valid || !req_valid,
      req_ready == (!rsp_valid || rsp_ready), "input stalled while output free")
   `PCT_ASSERT_IMP(a_reset_empty, clock, reset, $past(reset), !rsp_valid,
      "item out right after reset")

endmodule

bind pair_collision_time pct_props u_pct_props (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_no_hit   (rsp_ch.no_hit),
   .rsp_hit_time (rsp_ch.hit_time)
);

### test/pct_checker.sv
`timescale 1ns / 1ps

module pct_checker (
   input  logic clock,
   input  logic reset,
   pct_req_if   req,
   pct_rsp_if   rsp,
   pct_csr_if   csr,
   output int   fail_count,
   output int   pending,
   output int   checked,
   output int   hits_seen
);
   typedef logic [255:0] wide_type;
   typedef struct {
      logic signed [pct_pkg::CW-1:0] pa[3];
      logic signed [pct_pkg::CW-1:0] pb[3];
      logic signed [pct_pkg::CW-1:0] va[3];
      logic signed [pct_pkg::CW-1:0] vb[3];
   } pair_type;
   typedef struct {
      logic                          no_hit;
      logic signed [pct_pkg::TW-1:0] hit_time;
   } contact_type;

   localparam int FB = pct_pkg::FRAC_DEFAULT;
   localparam wide_type TMAX = (wide_type'(1) << (pct_pkg::TW - 1)) - 1;

   logic [pct_pkg::CW-1:0] sigma;
   contact_type            contact_q[$];

   function automatic contact_type contact_time(pair_type p, logic [pct_pkg::CW-1:0] sig);
      wide_type    closing, opening, vv, xx, d1, d1sq, sb, e, ve, disc, root, cand, num, q;
      longint      dx, dv, mdx, mdv;
      logic        negative;
      contact_type r;
      closing = '0; opening = '0; vv = '0; xx = '0;
      r.no_hit = 1'b1;
      r.hit_time = '0;
      for (int i = 0; i < pct_pkg::DIM_DEFAULT; i++) begin
         dx = longint'(p.pb[i]) - longint'(p.pa[i]);
         dv = longint'(p.vb[i]) - longint'(p.va[i]);
         mdx = dx < 0 ? -dx : dx;
         mdv = dv < 0 ? -dv : dv;
         if ((dx < 0) != (dv < 0)) closing += wide_type'(mdx) * wide_type'(mdv);
         else opening += wide_type'(mdx) * wide_type'(mdv);
         vv += wide_type'(mdv) * wide_type'(mdv);
         xx += wide_type'(mdx) * wide_type'(mdx);
      end
      if (opening >= closing) return r;
      d1 = closing - opening;
      d1sq = d1 * d1;
      sb = wide_type'(sig) * wide_type'(sig);
      if (xx >= sb) begin
         e = xx - sb;
         ve = vv * e;
         if (d1sq < ve) return r;
         disc = d1sq - ve;
      end else begin
         e = sb - xx;
         ve = vv * e;
         disc = d1sq + ve;
      end
      root = '0;
      for (int k = 111; k >= 0; k--) begin
         cand = root | (wide_type'(1) << k);
         if (cand * cand <= disc) root = cand;
      end
      negative = root > d1;
      num = negative ? root - d1 : d1 - root;
      q = (num << FB) / vv;
      if (negative) begin
         if (q > TMAX + 1) q = TMAX + 1;
         q = -q;
      end else if (q > TMAX) begin
         q = TMAX;
      end
      r.no_hit = 1'b0;
      r.hit_time = q[pct_pkg::TW-1:0];
      return r;
   endfunction

   assign pending = contact_q.size();

   always @(posedge clock) begin
      pair_type    p;
      contact_type want;
      if (reset) begin
         sigma <= pct_pkg::CD_RESET;
         fail_count <= 0;
         checked <= 0;
         hits_seen <= 0;
      end else begin
         if (csr.valid && csr.ready) sigma <= csr.contact_distance;
         if (rsp.valid && rsp.ready) begin
            checked <= checked + 1;
            if (!rsp.no_hit) hits_seen <= hits_seen + 1;
            if (contact_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result item at %0t", $realtime);
               fail_count <= fail_count + 1;
            end else begin
               want = contact_q.pop_front();
               if (rsp.no_hit !== want.no_hit || rsp.hit_time !== want.hit_time) begin
                  if (fail_count < 10)
                     $display("mismatch: expected no_hit=%0b time=%0d, got no_hit=%0b time=%0d",
                              want.no_hit, want.hit_time, rsp.no_hit, rsp.hit_time);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req.valid && req.ready) begin
            p.pa = '{req.pos_a_x, req.pos_a_y, req.pos_a_z};
            p.pb = '{req.pos_b_x, req.pos_b_y, req.pos_b_z};
            p.va = '{req.vel_a_x, req.vel_a_y, req.vel_a_z};
            p.vb = '{req.vel_b_x, req.vel_b_y, req.vel_b_z};
            contact_q.insert(contact_q.size(), contact_time(p, sigma));
         end
      end
   end
endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
   typedef logic signed [pct_pkg::CW-1:0] word_type;

   localparam int WATCHDOG = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic quiet = 1'b0;
   logic done = 1'b0;
   int   fail_count, pending, checked, hits_seen;
   int   stall_left, idle_cycles;
   int   settings = 0;

   pct_req_if req ();
   pct_rsp_if rsp ();
   pct_csr_if csr ();

   pair_collision_time u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp),
      .csr_ch (csr)
   );

   pct_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .csr        (csr),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .hits_seen  (hits_seen)
   );

   always #1 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      {req.pos_a_x, req.pos_a_y, req.pos_a_z, req.pos_b_x, req.pos_b_y, req.pos_b_z} = '0;
      {req.vel_a_x, req.vel_a_y, req.vel_a_z, req.vel_b_x, req.vel_b_y, req.vel_b_z} = '0;
      csr.valid = 1'b0;
      csr.contact_distance = '0;
      rsp.ready = 1'b0;
   end

   // result side back-pressure in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready <= stall_left == 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, 5);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // no-progress watchdog
   always @(posedge clock) begin
      if (reset || done || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_pair(word_type v[12]);
      int gap;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 5);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.pos_a_x <= v[0]; req.pos_a_y <= v[1]; req.pos_a_z <= v[2];
      req.pos_b_x <= v[3]; req.pos_b_y <= v[4]; req.pos_b_z <= v[5];
      req.vel_a_x <= v[6]; req.vel_a_y <= v[7]; req.vel_a_z <= v[8];
      req.vel_b_x <= v[9]; req.vel_b_y <= v[10]; req.vel_b_z <= v[11];
      req.valid <= 1'b1;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic set_contact(logic [pct_pkg::CW-1:0] sig);
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (140) @(posedge clock);
      csr.contact_distance <= sig;
      csr.valid <= 1'b1;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      settings++;
   endtask

   function automatic word_type spread(int bits);
      longint m;
      m = longint'(1) << bits;
      return word_type'(longint'($urandom_range(0, 32'(2 * m - 1))) - m);
   endfunction

   function automatic void random_pair(output word_type v[12]);
      int mode, s;
      word_type d;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 12; i++) v[i] = word_type'($urandom);
      if (mode < 2) return;
      s = mode >= 8 ? $urandom_range(12, 20) : $urandom_range(8, 29);
      for (int i = 0; i < 3; i++) begin
         d = spread(s);
         v[3 + i] = v[i] + d;
         v[6 + i] = spread($urandom_range(4, 30));
         v[9 + i] = v[6 + i] - (d >>> $urandom_range(0, 5)) + spread(s > 8 ? s - 7 : 1);
      end
   endfunction

   initial begin
      word_type v[12];
      word_type mn, mx;
      logic [pct_pkg::CW-1:0] sigmas[6];
      mn = word_type'(32'h8000_0000);
      mx = word_type'(32'h7fff_ffff);
      sigmas = '{pct_pkg::CD_RESET, 32'd0, 32'hffff_ffff, 32'h0100_0000, 32'h0, 32'd335544};
      sigmas[4] = $urandom;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      v = '{default: 0};
      send_pair(v);                                              // identical spheres
      v = '{default: mx};
      send_pair(v);
      v = '{default: mn};
      send_pair(v);
      v = '{mn, mn, mn, mx, mx, mx, mx, mx, mx, mn, mn, mn};  // widest head-on
      send_pair(v);
      v = '{mx, mx, mx, mn, mn, mn, mn, mn, mn, mx, mx, mx};
      send_pair(v);
      v = '{mn, 0, 0, mx, 0, 0, 0, 0, 0, -1, 0, 0};            // far and slow, saturates
      send_pair(v);
      v = '{0, 0, 0, 1000000, 0, 0, 0, 0, 0, -16777216, 0, 0}; // head-on hit
      send_pair(v);
      v = '{0, 0, 0, 1000000, 0, 0, 0, 0, 0, 16777216, 0, 0}; // separating
      send_pair(v);
      v = '{0, 0, 0, 1000000, 5000000, 0, 0, 0, 0, -16777216, 0, 0}; // miss
      send_pair(v);
      v = '{0, 0, 0, 100, 0, 0, 0, 0, 0, -16777216, 0, 0};    // overlapping
      send_pair(v);
      v = '{0, 0, 0, 1, 0, 0, 0, 0, 0, -1, 0, 0};             // overlapping, crawling
      send_pair(v);
      v = '{0, 0, 0, 0, 335544, 0, 0, 0, 0, 0, -1000, 0};     // touching
      send_pair(v);
      v = '{0, 0, 0, 1000000, 1000000, 1000000, 0, 0, 0, -1, -1, -1};
      send_pair(v);

      for (int ph = 0; ph < 6; ph++) begin
         set_contact(sigmas[ph]);
         if (ph == 5) quiet = 1'b1;
         repeat (330) begin
            random_pair(v);
            send_pair(v);
         end
         // top up with one directed pair per setting
         v = '{0, 0, 0, 100, 0, 0, 0, 0, 0, -1, 0, 0};
         send_pair(v);
      end
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      done = 1'b1;

      $display("checked %0d result items, %0d of them hits, over %0d contact distances",
               checked, hits_seen, settings);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
